// ===== rtl/core/adc_ema_q15_dac_filter_defines.svh =====
// ----------------------------------------------------------------------------
// adc_ema_q15_dac_filter assertion macros
// Shared wrappers for the concurrent checks on the filter ports.
// ----------------------------------------------------------------------------
`ifndef ADC_EMA_Q15_DAC_FILTER_DEFINES_SVH
`define ADC_EMA_Q15_DAC_FILTER_DEFINES_SVH

// property under reset gating
`define AEDF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// overlapping implication under reset gating
`define AEDF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset gating
`define AEDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/aedf_pkg.sv =====
// ----------------------------------------------------------------------------
// aedf_pkg
// Types and constants shared by the converter EMA filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aedf_pkg;

    // default converter sample width
    localparam int SAMPLE_BITS_DEF = 12;

    // q15 limits and register reset
    localparam int             Q15_MAX     = 32767;
    localparam logic [14:0]    Q15_MAX_U   = 15'h7FFF;
    localparam logic [14:0]    ALPHA_RESET = 15'd6553;

    // offset of the sample line, unsigned q16 (about 36407.78)
    localparam longint unsigned OFFSET_Q16 = 64'd2386020124;

    typedef logic signed [15:0] q15_t;

    // front to queue transfer
    typedef struct packed {
        logic valid;
        q15_t data;
    } push_t;

    // queue head seen by the back end
    typedef struct packed {
        logic not_empty;
        q15_t data;
    } queue_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/aedf_front.sv =====
// ----------------------------------------------------------------------------
// aedf_front
// Accepts converter samples and maps each one to a clamped q15 value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aedf_front #(
    parameter int SAMPLE_BITS = aedf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] adc_sample,
    output aedf_pkg::push_t             push,
    input  wire logic                   queue_full
);
    import aedf_pkg::*;

    // gain in unsigned q16, rounded
    localparam longint unsigned FULL_SCALE = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam longint unsigned GAIN_Q16 =
        (64'd11 * 64'd32767 * 64'd65536 + (64'd3 * FULL_SCALE) / 64'd2) /
        (64'd3 * FULL_SCALE);
    localparam int GAIN_W = $clog2(GAIN_Q16 + 64'd1);
    localparam int PW     = SAMPLE_BITS + GAIN_W;
    localparam int VW     = ((PW > 32) ? PW : 32) + 1;
    localparam int QW     = VW - 16;

    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        prod_next;
    logic                 prod_valid_reg;
    logic                 prod_valid_next;
    logic                 accept;
    logic signed [VW-1:0] v;
    logic [VW-1:0]        mag;
    logic [QW-1:0]        qm;
    logic [14:0]          qc;
    logic                 neg;
    q15_t                 x;

    // product stage handshake
    assign in_stall = prod_valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        prod_next       = prod_reg;
        prod_valid_next = prod_valid_reg;
        if (accept)
        begin
            prod_next       = PW'(adc_sample) * PW'(GAIN_Q16);
            prod_valid_next = 1'b1;
        end
        else if (prod_valid_reg && !queue_full)
        begin
            prod_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // remove offset, truncate toward zero, clamp to +-32767
    always_comb
    begin
        v   = signed'(VW'(prod_reg)) - signed'(VW'(OFFSET_Q16));
        neg = v[VW-1];
        mag = neg ? VW'(-v) : VW'(v);
        qm  = mag[VW-1:16];
        qc  = (qm > QW'(Q15_MAX)) ? Q15_MAX_U : qm[14:0];
        x   = neg ? -signed'({1'b0, qc}) : signed'({1'b0, qc});
    end

    assign push.valid = prod_valid_reg && !queue_full;
    assign push.data  = x;

endmodule

`default_nettype wire

// ===== rtl/core/aedf_queue.sv =====
// ----------------------------------------------------------------------------
// aedf_queue
// Two-entry queue of mapped samples between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aedf_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire aedf_pkg::push_t push,
    output logic                 full,
    output aedf_pkg::queue_head_t head,
    input  wire logic            pop
);
    import aedf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    q15_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full           = (count_reg == CNT_W'(DEPTH));
    assign head.not_empty = (count_reg != '0);
    assign head.data      = entry_reg[rd_ptr_reg];
    assign do_pop         = pop && head.not_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/aedf_back.sv =====
// ----------------------------------------------------------------------------
// aedf_back
// EMA sequencer on one shared multiplier, DAC mapping and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aedf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [14:0]      cfg_wr_data,
    input  wire aedf_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output aedf_pkg::q15_t        filtered_q15,
    output logic [11:0]           dac_code
);
    import aedf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL2 = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_DAC  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [14:0]        alpha_reg;
    q15_t               last_reg;
    q15_t               last_next;
    logic signed [31:0] prod_reg;
    logic signed [31:0] prod_next;
    q15_t               r1_reg;
    q15_t               r1_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    q15_t               q15_out_reg;
    logic [11:0]        dac_out_reg;
    logic               load_out;
    logic [14:0]        coef;
    q15_t               mul_a;
    q15_t               mul_b;

    // rounded, saturating q15 product
    function automatic q15_t qsat(input logic signed [31:0] p);
        logic signed [32:0] s;
        logic signed [17:0] r;
        q15_t               res;
        s = {p[31], p} + 33'sd16384;
        r = s[32:15];
        if (r > 18'sd32767)
        begin
            res = 16'sh7FFF;
        end
        else if (r < -18'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = r[15:0];
        end
        return res;
    endfunction

    // 2048 + floor(y*2048/32767), clamped to the 12-bit range
    function automatic logic [11:0] to_dac(input q15_t y);
        logic signed [16:0] rem;
        logic signed [12:0] k;
        logic signed [13:0] d;
        logic [11:0]        res;
        rem = signed'({2'b00, y[3:0], 11'b0}) + signed'({{5{y[15]}}, y[15:4]});
        k   = signed'({y[15], y[15:4]});
        if (rem >= 17'sd32767)
        begin
            k = k + 13'sd1;
        end
        else if (rem < 17'sd0)
        begin
            k = k - 13'sd1;
        end
        d = {k[12], k} + 14'sd2048;
        if (d < 14'sd0)
        begin
            res = 12'd0;
        end
        else if (d > 14'sd4095)
        begin
            res = 12'd4095;
        end
        else
        begin
            res = d[11:0];
        end
        return res;
    endfunction

    // weight register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_wr_en)
        begin
            alpha_reg <= cfg_wr_data;
        end
    end

    assign coef     = Q15_MAX_U - alpha_reg;
    assign load_out = (state_reg == ST_DAC) && (!out_valid_reg || !out_stall);
    assign pop      = (state_reg == ST_IDLE) && head.not_empty;

    // shared multiplier operands
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mul_a = signed'({1'b0, alpha_reg});
            mul_b = head.data;
        end
        else
        begin
            mul_a = signed'({1'b0, coef});
            mul_b = last_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        r1_next        = r1_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.not_empty)
                begin
                    prod_next  = mul_a * mul_b;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                r1_next    = qsat(prod_reg);
                prod_next  = mul_a * mul_b;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                last_next  = r1_reg + qsat(prod_reg);
                state_next = ST_DAC;
            end
            ST_DAC:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        r1_reg   <= r1_next;
        if (load_out)
        begin
            q15_out_reg <= last_reg;
            dac_out_reg <= to_dac(last_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign filtered_q15 = q15_out_reg;
    assign dac_code     = dac_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/adc_ema_q15_dac_filter.sv =====
// An input sample passes the front product register, the queue, the back-end
// sequencer and the output register. The sequencer takes a new sample only when
// idle and runs both q15 products through one multiplier, then the sum and the DAC mapping.
// The front end and a two-entry queue keep taking samples while a result waits.
// Reset clears the filter history to 0, alpha to 6553 and all valid flags.
// ----------------------------------------------------------------------------
// adc_ema_q15_dac_filter
// Converter sample to q15, single-pole EMA, and 12-bit DAC code mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adc_ema_q15_dac_filter #(
    parameter int SAMPLE_BITS = aedf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [14:0]            cfg_wr_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output aedf_pkg::q15_t              filtered_q15,
    output logic [11:0]                 dac_code
);
    import aedf_pkg::*;

    push_t       push;
    queue_head_t head;
    logic        queue_full;
    logic        pop;

    // sample mapping
    aedf_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .push       (push),
        .queue_full (queue_full)
    );

    // decoupling queue
    aedf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    // filter and output
    aedf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered_q15 (filtered_q15),
        .dac_code     (dac_code)
    );

endmodule

`default_nettype wire

// ===== rtl/core/aedf_checker.sv =====
// ----------------------------------------------------------------------------
// aedf_checker
// Port-level checks on the filter result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "adc_ema_q15_dac_filter_defines.svh"

module aedf_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [15:0] filtered_q15,
    input  wire logic [11:0] dac_code
);

    // a stalled result holds
    `AEDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(filtered_q15) && $stable(dac_code), "stalled result changed")

    // dac code lies on the same side of mid-scale as the q15 value
    `AEDF_ASSERT_IMPL(a_dac_sign, clk, rst_n, out_valid, dac_code[11] == !filtered_q15[15], "dac code sign mismatch")

    // zero maps to mid-scale
    `AEDF_ASSERT_IMPL(a_dac_mid, clk, rst_n, out_valid && (filtered_q15 == 16'h0000), dac_code == 12'd2048, "zero not at mid-scale")

    // most negative value clamps to code zero
    `AEDF_ASSERT(a_dac_low, clk, rst_n, !(out_valid && (filtered_q15 == 16'h8000)) || (dac_code == 12'd0), "negative full scale not clamped")

endmodule

bind adc_ema_q15_dac_filter aedf_checker u_aedf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered_q15 (filtered_q15),
    .dac_code     (dac_code)
);

`default_nettype wire
